// ===== design/page_frame_bitmap_allocator_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PFA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pfa_pkg.sv =====
// Package with constants and types of the page frame allocator.
package pfa_pkg;
  localparam int ModeW = 2;
  localparam int LenW = 19;
  localparam int AddrW = 48;
  localparam int StatusW = 2;
  localparam int FaddrW = 30;
  localparam int CountW = 19;
  localparam int WordW = 32;

  localparam logic [ModeW-1:0] MODE_ALLOC_ONE = 2'd0;
  localparam logic [ModeW-1:0] MODE_ALLOC_RUN = 2'd1;
  localparam logic [ModeW-1:0] MODE_FREE_RUN = 2'd2;

  localparam logic [StatusW-1:0] ST_DONE = 2'd0;
  localparam logic [StatusW-1:0] ST_FAIL = 2'd1;
  localparam logic [StatusW-1:0] ST_SKIPPED = 2'd2;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [LenW-1:0] run_length;
    logic [AddrW-1:0] address;
  } pfa_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FaddrW-1:0] frame_address;
    logic [CountW-1:0] frames_released;
    logic [CountW-1:0] free_count;
  } pfa_rsp_t;
endpackage

// ===== design/pfa_if.sv =====
// Valid/ready channel interface carrying one payload.
interface pfa_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/pfa_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module pfa_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== design/page_frame_bitmap_allocator_top.sv =====
// Page frame allocator: one bit per frame in a word RAM, scanned first fit.
// After reset a clearing pass writes every bitmap word once (8192 words by default)
// and no request is taken meanwhile. The search reads a bitmap word and then checks
// one frame bit per cycle. A single allocate reads words and checks bits until it finds
// a clear one, a run allocate marks each frame of the found run with a read and then a
// write back, a free reads each frame in turn and clears it if set, and a rejected
// request goes straight to the output state. The single RAM port and the bit walk pace
// all of these, and a stalled result holds the block in its output state.
module page_frame_bitmap_allocator_top
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES = 262144,
  parameter int RESERVED_FRAMES = 1024,
  parameter int FRAME_SHIFT = 12
) (
  input  logic clk,
  input  logic rst_n,
  pfa_if.sink   in_req,
  pfa_if.source out_rsp
);
  localparam int Words = (NUM_FRAMES + WordW - 1) / WordW;
  localparam int WaW = (Words > 1) ? $clog2(Words) : 1;
  localparam int FrW = $clog2(NUM_FRAMES) + 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  pfa_req_t req_r;
  logic [FrW-1:0] f_r, f_nxt;
  logic [FrW-1:0] start_r, start_nxt;
  logic [LenW-1:0] run_r, run_nxt;
  logic [LenW-1:0] idx_r, idx_nxt;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [CountW-1:0] rel_r, rel_nxt;
  logic [StatusW-1:0] st_r, st_nxt;
  logic [FaddrW-1:0] fa_r, fa_nxt;
  logic [WaW-1:0] clr_r, clr_nxt;
  logic out_v_r, out_v_nxt;

  logic ram_we;
  logic [WaW-1:0] ram_addr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  pfa_ram #(.Width(WordW), .Depth(Words)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // Free address for the current index, formed as a 64-bit sum.
  logic [63:0] faddr64;
  logic [63:0] frn64;
  logic free_ok_addr;
  assign faddr64 = {16'd0, req_r.address} + ({45'd0, idx_r} << FRAME_SHIFT);
  assign frn64 = faddr64 >> FRAME_SHIFT;
  assign free_ok_addr = (faddr64 != 64'd0) && (frn64 < 64'(NUM_FRAMES))
                        && (frn64 >= 64'(RESERVED_FRAMES));

  logic [FrW-1:0] cur_f;
  logic cur_bit;
  logic [4:0] cur_bi;
  logic [WordW-1:0] clr_word;
  logic [FrW+WaW:0] clr_base;

  assign cur_f = (req_r.mode == MODE_FREE_RUN) ? frn64[FrW-1:0] : f_r;
  assign cur_bi = cur_f[4:0];
  assign cur_bit = ram_rdata[cur_bi];
  assign clr_base = {{(FrW+1){1'b0}}, clr_r} << 5;

  always_comb begin
    for (int b = 0; b < WordW; b++) begin
      clr_word[b] = ((clr_base + (FrW+WaW+1)'(b)) < (FrW+WaW+1)'(RESERVED_FRAMES));
    end
  end

  always_comb begin
    state_nxt = state_r;
    f_nxt = f_r;
    start_nxt = start_r;
    run_nxt = run_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    rel_nxt = rel_r;
    st_nxt = st_r;
    fa_nxt = fa_r;
    clr_nxt = clr_r;
    out_v_nxt = out_v_r;
    ram_we = 1'b0;
    ram_addr = cur_f[WaW+4:5];
    ram_wdata = ram_rdata;
    if (out_v_r && out_rsp.ready) begin
      out_v_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = clr_r;
        ram_wdata = clr_word;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == WaW'(Words - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req.valid) begin
          f_nxt = FrW'(RESERVED_FRAMES);
          run_nxt = '0;
          idx_nxt = '0;
          rel_nxt = '0;
          st_nxt = ST_FAIL;
          fa_nxt = '0;
          state_nxt = S_READ;
          if (in_req.data.mode == MODE_ALLOC_ONE && cnt_r == '0) begin
            state_nxt = S_OUT;
          end
          if (in_req.data.mode == MODE_ALLOC_RUN &&
              (in_req.data.run_length == '0 || in_req.data.run_length > cnt_r)) begin
            state_nxt = S_OUT;
          end
          if (in_req.data.mode == MODE_FREE_RUN && in_req.data.run_length == '0) begin
            st_nxt = ST_SKIPPED;
            state_nxt = S_OUT;
          end
          if (in_req.data.mode != MODE_ALLOC_ONE && in_req.data.mode != MODE_ALLOC_RUN
              && in_req.data.mode != MODE_FREE_RUN) begin
            state_nxt = S_OUT;
          end
          if (RESERVED_FRAMES >= NUM_FRAMES && in_req.data.mode != MODE_FREE_RUN) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r.mode == MODE_FREE_RUN) begin
          if (free_ok_addr && cur_bit) begin
            ram_we = 1'b1;
            ram_wdata[cur_bi] = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
            rel_nxt = rel_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_READ;
          if (idx_r + 1'b1 == req_r.run_length) begin
            state_nxt = S_OUT;
            st_nxt = ((rel_r != '0) || (free_ok_addr && cur_bit)) ? ST_DONE : ST_SKIPPED;
          end
        end else if (req_r.mode == MODE_ALLOC_ONE) begin
          // Walk the current word bit by bit; advance word when exhausted.
          if (!cur_bit) begin
            ram_we = 1'b1;
            ram_wdata[cur_bi] = 1'b1;
            cnt_nxt = cnt_r - 1'b1;
            fa_nxt = FaddrW'({{FaddrW{1'b0}}, f_r} << FRAME_SHIFT);
            st_nxt = ST_DONE;
            state_nxt = S_OUT;
          end else begin
            f_nxt = f_r + 1'b1;
            if (f_r + 1'b1 == FrW'(NUM_FRAMES)) begin
              state_nxt = S_OUT;
            end else if (cur_bi == 5'd31) begin
              state_nxt = S_READ;
            end
          end
        end else begin
          if (cur_bit) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_r + 1'b1;
            if (run_r == '0) begin
              start_nxt = f_r;
            end
          end
          if (!cur_bit && run_r + 1'b1 == req_r.run_length) begin
            f_nxt = (run_r == '0) ? f_r : start_r;
            fa_nxt = FaddrW'({{FaddrW{1'b0}}, ((run_r == '0) ? f_r : start_r)}
                             << FRAME_SHIFT);
            cnt_nxt = cnt_r - CountW'(req_r.run_length);
            st_nxt = ST_DONE;
            idx_nxt = '0;
            state_nxt = S_MARK;
          end else begin
            f_nxt = f_r + 1'b1;
            if (f_r + 1'b1 == FrW'(NUM_FRAMES)) begin
              state_nxt = S_OUT;
            end else if (cur_bi == 5'd31) begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_MARK: begin
        // Read-modify-write of each frame in the found run.
        if (idx_r[0] == 1'b0) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          ram_we = 1'b1;
          ram_wdata[cur_bi] = 1'b1;
          idx_nxt = '0;
          run_nxt = run_r - 1'b1;
          f_nxt = f_r + 1'b1;
          if (run_r == LenW'(1)) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_v_r || out_rsp.ready) begin
          out_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_req.ready = (state_r == S_IDLE);
  assign out_rsp.valid = out_v_r;

  pfa_rsp_t rsp_r;
  assign out_rsp.data = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_v_r <= 1'b0;
      cnt_r <= (RESERVED_FRAMES < NUM_FRAMES) ? CountW'(NUM_FRAMES - RESERVED_FRAMES)
                                              : '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_v_r <= out_v_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_req.valid) begin
      req_r <= in_req.data;
    end
    f_r <= f_nxt;
    start_r <= start_nxt;
    run_r <= run_nxt;
    idx_r <= idx_nxt;
    rel_r <= rel_nxt;
    st_r <= st_nxt;
    fa_r <= fa_nxt;
    if (state_r == S_OUT && (!out_v_r || out_rsp.ready)) begin
      rsp_r.status <= st_r;
      rsp_r.frame_address <= fa_r;
      rsp_r.frames_released <= rel_r;
      rsp_r.free_count <= cnt_r;
    end
  end
endmodule

// ===== design/pfa_checker.sv =====
// Port-level checker for the page frame allocator, bound to the top level.
`include "page_frame_bitmap_allocator_top_defines.svh"
module pfa_checker
  import pfa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pfa_rsp_t out_data
);
  `PFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `PFA_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_data.status <= ST_SKIPPED, "bad status code")
  `PFA_ASSERT_IMPL(a_fail_addr, clk, rst_n, out_valid && out_data.status != ST_DONE, out_data.frame_address == '0, "failed request returned an address")
  `PFA_ASSERT_NEXT(a_one_req, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken while busy")
endmodule

bind page_frame_bitmap_allocator_top pfa_checker u_pfa_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_data(out_rsp.data)
);
